// ===== hw/rtl/normal_light_shade_quantizer_top_assert.svh =====
// Assertion macros used by the shade quantizer top module.
`ifndef NORMAL_LIGHT_SHADE_QUANTIZER_TOP_ASSERT_SVH
`define NORMAL_LIGHT_SHADE_QUANTIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define NLSQ_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("shade quantizer assertion failed");
`define NLSQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("shade quantizer assertion failed");
`else
`define NLSQ_ASSERT(lbl, cond)
`define NLSQ_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== hw/rtl/nlsq_pkg.sv =====
// Shared types and constants of the normal light shade quantizer.
package nlsq_pkg;

  localparam int NORMAL_W  = 8;
  localparam int VEC_W     = 24;
  localparam int QUANT_W   = 22;
  localparam int CFG_IDX_W = 3;
  localparam int MAG_W     = 8;
  localparam int PROD_W    = 16;
  localparam int SUM_W     = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_DIR       = 3'd0,
    CFG_HALF_FRONT      = 3'd1,
    CFG_HALF_BACK       = 3'd2,
    CFG_DIFFUSE_QUANT   = 3'd3,
    CFG_SPECULAR_QUANT  = 3'd4,
    CFG_SPECULAR_ENABLE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/nlsq_dot.sv =====
// Three-stage dot product, scale by 64 toward zero, clamp and sign split.
module nlsq_dot (
  input  logic                                 clk,
  input  nlsq_pkg::pipe_ctl_t                  ctl,
  input  logic signed [nlsq_pkg::NORMAL_W-1:0] n_x,
  input  logic signed [nlsq_pkg::NORMAL_W-1:0] n_y,
  input  logic signed [nlsq_pkg::NORMAL_W-1:0] n_z,
  input  logic        [nlsq_pkg::VEC_W-1:0]    vec,
  output logic                                 pos,
  output logic        [nlsq_pkg::MAG_W-1:0]    mag
);

  logic signed [nlsq_pkg::PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [nlsq_pkg::SUM_W-1:0]  sum_r;
  logic signed [nlsq_pkg::SUM_W-1:0]  sum_bias;
  logic signed [nlsq_pkg::SUM_W-1:0]  q;
  logic signed [nlsq_pkg::SUM_W-1:0]  q_neg;
  logic                               pos_nxt, pos_r;
  logic        [nlsq_pkg::MAG_W-1:0]  mag_nxt, mag_r;
  logic signed [nlsq_pkg::NORMAL_W-1:0] vx, vy, vz;

  assign vx = vec[7:0];
  assign vy = vec[15:8];
  assign vz = vec[23:16];

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      px_r <= n_x * vx;
      py_r <= n_y * vy;
      pz_r <= n_z * vz;
    end
    if (ctl.en2) begin
      sum_r <= nlsq_pkg::SUM_W'(px_r) + nlsq_pkg::SUM_W'(py_r) + nlsq_pkg::SUM_W'(pz_r);
    end
    if (ctl.en3) begin
      pos_r <= pos_nxt;
      mag_r <= mag_nxt;
    end
  end

  // Biasing negative sums by 63 makes the arithmetic shift truncate toward zero.
  assign sum_bias = sum_r + (sum_r[nlsq_pkg::SUM_W-1] ? 17'sd63 : 17'sd0);
  assign q        = sum_bias >>> 6;
  assign q_neg    = -q;

  always_comb begin
    if (q > 17'sd255) begin
      pos_nxt = 1'b1;
      mag_nxt = 8'd255;
    end else if (q < -17'sd255) begin
      pos_nxt = 1'b0;
      mag_nxt = 8'd255;
    end else if (q[nlsq_pkg::SUM_W-1]) begin
      pos_nxt = 1'b0;
      mag_nxt = q_neg[7:0];
    end else begin
      pos_nxt = (q != 17'sd0);
      mag_nxt = q[7:0];
    end
  end

  assign pos = pos_r;
  assign mag = mag_r;

endmodule

// ===== hw/rtl/normal_light_shade_quantizer_top.sv =====
// An accepted request passes the multiply, sum and clamp registers into the output register.
// Throughput: one request per cycle unless stalled; every stage takes a new request each free cycle.
// Stages: multiply, sum, scale and clamp, then quantize into the output register.
// A stalled output holds; earlier stages keep filling until the pipeline is full.
// Reset (rst_n low, synchronous) clears all valid bits and all configuration registers.
`include "normal_light_shade_quantizer_top_assert.svh"

module normal_light_shade_quantizer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic        [nlsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [nlsq_pkg::VEC_W-1:0]    cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [nlsq_pkg::NORMAL_W-1:0] in_normal_x,
  input  logic signed [nlsq_pkg::NORMAL_W-1:0] in_normal_y,
  input  logic signed [nlsq_pkg::NORMAL_W-1:0] in_normal_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_front_facing,
  output logic        [nlsq_pkg::MAG_W-1:0]    out_diffuse_index,
  output logic        [nlsq_pkg::MAG_W-1:0]    out_specular_index
);

  function automatic logic [7:0] quantize(input logic [7:0] s, input logic [2:0] sh,
                                          input logic [7:0] mx);
    logic [7:0] idx;
    logic       rnd;
    logic [8:0] total;
    idx   = s >> sh;
    rnd   = (sh != 3'd0) && s[sh - 3'd1];
    total = {1'b0, idx} + {8'd0, rnd};
    quantize = (total < {1'b0, mx}) ? total[7:0] : mx;
  endfunction

  logic [nlsq_pkg::VEC_W-1:0]   light_dir_r, half_front_r, half_back_r;
  logic [nlsq_pkg::QUANT_W-1:0] diffuse_quant_r, specular_quant_r;
  logic                         specular_enable_r;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en_out;
  logic en1, en2, en3;
  nlsq_pkg::pipe_ctl_t ctl;

  logic                        diff_pos;
  logic [nlsq_pkg::MAG_W-1:0]  diff_mag, spec_front_mag, spec_back_mag;
  logic                        spec_front_pos, spec_back_pos;
  logic [nlsq_pkg::MAG_W-1:0]  spec_mag;
  logic [2:0]                  d_sh, s_sh;
  logic [7:0]                  d_mx, s_mx;

  logic                        front_r;
  logic [nlsq_pkg::MAG_W-1:0]  diffuse_r, specular_r;
  logic [nlsq_pkg::MAG_W-1:0]  diffuse_nxt, specular_nxt;
  logic [7:0]                  out_cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_dir_r       <= '0;
      half_front_r      <= '0;
      half_back_r       <= '0;
      diffuse_quant_r   <= '0;
      specular_quant_r  <= '0;
      specular_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nlsq_pkg::CFG_LIGHT_DIR:       light_dir_r       <= cfg_wdata;
        nlsq_pkg::CFG_HALF_FRONT:      half_front_r      <= cfg_wdata;
        nlsq_pkg::CFG_HALF_BACK:       half_back_r       <= cfg_wdata;
        nlsq_pkg::CFG_DIFFUSE_QUANT:   diffuse_quant_r   <= cfg_wdata[nlsq_pkg::QUANT_W-1:0];
        nlsq_pkg::CFG_SPECULAR_QUANT:  specular_quant_r  <= cfg_wdata[nlsq_pkg::QUANT_W-1:0];
        nlsq_pkg::CFG_SPECULAR_ENABLE: specular_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign en_out   = !out_valid_r || !out_stall;
  assign en3      = !v3_r || en_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign ctl      = '{en1: en1, en2: en2, en3: en3};
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r <= in_valid;
      if (en2)    v2_r <= v1_r;
      if (en3)    v3_r <= v2_r;
      if (en_out) out_valid_r <= v3_r;
    end
  end

  nlsq_dot u_diffuse (
    .clk (clk), .ctl (ctl),
    .n_x (in_normal_x), .n_y (in_normal_y), .n_z (in_normal_z),
    .vec (light_dir_r), .pos (diff_pos), .mag (diff_mag)
  );

  nlsq_dot u_spec_front (
    .clk (clk), .ctl (ctl),
    .n_x (in_normal_x), .n_y (in_normal_y), .n_z (in_normal_z),
    .vec (half_front_r), .pos (spec_front_pos), .mag (spec_front_mag)
  );

  nlsq_dot u_spec_back (
    .clk (clk), .ctl (ctl),
    .n_x (in_normal_x), .n_y (in_normal_y), .n_z (in_normal_z),
    .vec (half_back_r), .pos (spec_back_pos), .mag (spec_back_mag)
  );

  // Both half-vector dot products run in parallel; facing picks one at the last stage.
  always_comb begin
    spec_mag = diff_pos ? spec_front_mag : spec_back_mag;
    d_sh = diff_pos ? diffuse_quant_r[2:0]   : diffuse_quant_r[13:11];
    d_mx = diff_pos ? diffuse_quant_r[10:3]  : diffuse_quant_r[21:14];
    s_sh = diff_pos ? specular_quant_r[2:0]  : specular_quant_r[13:11];
    s_mx = diff_pos ? specular_quant_r[10:3] : specular_quant_r[21:14];
    diffuse_nxt  = quantize(diff_mag, d_sh, d_mx);
    specular_nxt = specular_enable_r ? quantize(spec_mag, s_sh, s_mx) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      front_r    <= diff_pos;
      diffuse_r  <= diffuse_nxt;
      specular_r <= specular_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_front_facing   = front_r;
  assign out_diffuse_index  = diffuse_r;
  assign out_specular_index = specular_r;

  assign out_cap = front_r ? diffuse_quant_r[10:3] : diffuse_quant_r[21:14];

  `NLSQ_ASSERT(a_stall_only_full, !in_stall || (v1_r && v2_r && v3_r && out_valid_r))
  `NLSQ_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v1_r)
  `NLSQ_ASSERT_NEXT(a_stage3_moves, v3_r && en_out, out_valid_r)
  `NLSQ_ASSERT(a_spec_disabled, !(out_valid_r && !specular_enable_r) || (specular_r == 8'd0))
  `NLSQ_ASSERT(a_diffuse_cap, !out_valid_r || (diffuse_r <= out_cap))

endmodule
